@@ design/plsti_pkg.sv @@
// Shared constants and types for the per-link subscription table insert block.
package plsti_pkg;

    localparam int NUM_LINKS   = 16;
    localparam int TABLE_DEPTH = 32;

    localparam int LINK_W      = 4;
    localparam int MSG_W       = 16;
    localparam int QUEUE_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int FILL_OUT_W  = 6;

    localparam int S_DATA_W    = ((LINK_W + MSG_W + QUEUE_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((STATUS_W + FILL_OUT_W + 7) / 8) * 8;

    localparam int ENTRY_W     = MSG_W + QUEUE_W;
    localparam int MEM_DEPTH   = NUM_LINKS * TABLE_DEPTH;
    localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int LINK_IDX_W  = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

    localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_WAIT   = 5'b00100,
        S_WRITE  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

endpackage

@@ design/plsti_ram.sv @@
// Generic simple dual-port RAM with registered read.
module plsti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

@@ design/per_link_subscription_table_insert_core.sv @@
// Top level: per-link subscription table insert with linear duplicate search.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: link_index, message_id, subscriber_queue
//  m_      | out | m_tvalid/m_tready  | m_tdata: status, fill_count
//
// An item for an empty table is written without a search; otherwise the entry memory
// read port scans the link's entries below its fill count, one entry per cycle, and
// the item is written unless a duplicate is found; a full table skips both. Reset
// clears all fill counts at once; entries are read only below the fill count, so
// no clearing pass. One item is in work at a time; a new item is taken while a
// result waits in the output register, and its own result holds until that drains.
module per_link_subscription_table_insert_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [3:0] link_index, [19:4] message_id, [35:20] subscriber_queue, zero fill
    input  logic [plsti_pkg::S_DATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] status, [7:2] fill_count
    output logic [plsti_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int ADDR_W  = plsti_pkg::ADDR_W;
    localparam int COUNT_W = plsti_pkg::COUNT_W;
    localparam int IDX_W   = plsti_pkg::IDX_W;

    plsti_pkg::state_t state_reg, state_next;

    logic [plsti_pkg::LINK_W-1:0]     link_reg, link_next;
    logic [plsti_pkg::MSG_W-1:0]      msg_reg, msg_next;
    logic [plsti_pkg::QUEUE_W-1:0]    queue_reg, queue_next;
    logic [COUNT_W-1:0]               count_reg, count_next;
    logic [IDX_W-1:0]                 rd_idx_reg, rd_idx_next;
    logic                             cmp_pend_reg, cmp_pend_next;
    logic                             hit_reg, hit_next;
    logic [plsti_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [COUNT_W-1:0]               res_fill_reg, res_fill_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [plsti_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [plsti_pkg::FILL_OUT_W-1:0] m_fill_reg, m_fill_next;

    logic [COUNT_W-1:0]               fill_reg [plsti_pkg::NUM_LINKS];
    logic                             fill_we;

    logic [plsti_pkg::LINK_W-1:0]     s_link;
    logic [plsti_pkg::LINK_IDX_W-1:0] s_link_idx;
    logic [plsti_pkg::LINK_IDX_W-1:0] link_idx;
    logic                             s_in_range;
    logic [COUNT_W-1:0]               s_count;

    logic [ADDR_W-1:0]                base_addr;
    logic                             mem_we;
    logic                             mem_re;
    logic [ADDR_W-1:0]                mem_waddr;
    logic [ADDR_W-1:0]                mem_raddr;
    logic [plsti_pkg::ENTRY_W-1:0]    mem_wdata;
    logic [plsti_pkg::ENTRY_W-1:0]    mem_rdata;
    logic                             match;

    assign s_link     = s_tdata[plsti_pkg::LINK_W-1:0];
    assign s_link_idx = plsti_pkg::LINK_IDX_W'(s_link);
    assign link_idx   = plsti_pkg::LINK_IDX_W'(link_reg);
    assign s_in_range = (32'(s_link) < 32'(plsti_pkg::NUM_LINKS));
    assign s_count    = s_in_range ? fill_reg[s_link_idx] : '0;

    assign base_addr  = ADDR_W'(link_reg) * ADDR_W'(plsti_pkg::TABLE_DEPTH);
    assign mem_raddr  = base_addr + ADDR_W'(rd_idx_reg);
    assign mem_waddr  = base_addr + ADDR_W'(count_reg);
    assign mem_wdata  = {queue_reg, msg_reg};
    assign match      = (mem_rdata == {queue_reg, msg_reg});

    assign s_tready   = (state_reg == plsti_pkg::S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {{(plsti_pkg::M_DATA_W - plsti_pkg::STATUS_W
                          - plsti_pkg::FILL_OUT_W){1'b0}}, m_fill_reg, m_status_reg};

    plsti_ram #(
        .WIDTH (plsti_pkg::ENTRY_W),
        .DEPTH (plsti_pkg::MEM_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        link_next       = link_reg;
        msg_next        = msg_reg;
        queue_next      = queue_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_pend_next   = 1'b0;
        hit_next        = hit_reg | (cmp_pend_reg & match);
        res_status_next = res_status_reg;
        res_fill_next   = res_fill_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_fill_next     = m_fill_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        fill_we         = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            plsti_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    link_next   = s_link;
                    msg_next    = s_tdata[plsti_pkg::LINK_W +: plsti_pkg::MSG_W];
                    queue_next  = s_tdata[plsti_pkg::LINK_W + plsti_pkg::MSG_W +:
                                          plsti_pkg::QUEUE_W];
                    count_next  = s_count;
                    rd_idx_next = '0;
                    hit_next    = 1'b0;
                    if (!s_in_range) begin
                        res_status_next = plsti_pkg::ST_FULL;
                        res_fill_next   = '0;
                        state_next      = plsti_pkg::S_FINISH;
                    end else if (32'(s_count) >= 32'(plsti_pkg::TABLE_DEPTH)) begin
                        res_status_next = plsti_pkg::ST_FULL;
                        res_fill_next   = s_count;
                        state_next      = plsti_pkg::S_FINISH;
                    end else if (s_count == '0) begin
                        state_next = plsti_pkg::S_WRITE;
                    end else begin
                        state_next = plsti_pkg::S_SEARCH;
                    end
                end
            end
            plsti_pkg::S_SEARCH: begin
                mem_re        = 1'b1;
                cmp_pend_next = 1'b1;
                if (COUNT_W'(rd_idx_reg) == count_reg - COUNT_W'(1)) begin
                    state_next = plsti_pkg::S_WAIT;
                end else begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            plsti_pkg::S_WAIT: begin
                if (hit_next) begin
                    res_status_next = plsti_pkg::ST_DUPLICATE;
                    res_fill_next   = count_reg;
                    state_next      = plsti_pkg::S_FINISH;
                end else begin
                    state_next = plsti_pkg::S_WRITE;
                end
            end
            plsti_pkg::S_WRITE: begin
                mem_we          = 1'b1;
                fill_we         = 1'b1;
                res_status_next = plsti_pkg::ST_ADDED;
                res_fill_next   = count_reg + COUNT_W'(1);
                state_next      = plsti_pkg::S_FINISH;
            end
            plsti_pkg::S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_fill_next   = plsti_pkg::FILL_OUT_W'(res_fill_reg);
                    state_next    = plsti_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = plsti_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= plsti_pkg::S_IDLE;
            cmp_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < plsti_pkg::NUM_LINKS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            cmp_pend_reg <= cmp_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (fill_we) begin
                fill_reg[link_idx] <= count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        link_reg       <= link_next;
        msg_reg        <= msg_next;
        queue_reg      <= queue_next;
        count_reg      <= count_next;
        rd_idx_reg     <= rd_idx_next;
        hit_reg        <= hit_next;
        res_status_reg <= res_status_next;
        res_fill_reg   <= res_fill_next;
        m_status_reg   <= m_status_next;
        m_fill_reg     <= m_fill_next;
    end

    a_write_below_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (32'(count_reg) < 32'(plsti_pkg::TABLE_DEPTH)))
        else $error("entry write at or beyond table depth");

    a_write_then_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == plsti_pkg::S_WRITE) |=> (state_reg == plsti_pkg::S_FINISH))
        else $error("write not followed by result");

    a_cmp_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_pend_reg |-> (state_reg == plsti_pkg::S_SEARCH || state_reg == plsti_pkg::S_WAIT))
        else $error("compare pending outside scan");

    a_added_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_status_reg == plsti_pkg::ST_ADDED) |-> (m_fill_reg != '0))
        else $error("added result with zero fill");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the per-link subscription table insert core.
module tb;
    import plsti_pkg::*;

    typedef struct packed {
        logic [QUEUE_W-1:0] queue;
        logic [MSG_W-1:0]   msg;
        logic [LINK_W-1:0]  link;
    } sub_req_t;

    typedef struct packed {
        logic [FILL_OUT_W-1:0] fill;
        logic [STATUS_W-1:0]   status;
    } sub_rsp_t;

    localparam int REQ_W       = LINK_W + MSG_W + QUEUE_W;
    localparam int RSP_W       = STATUS_W + FILL_OUT_W;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 280;
    localparam int HIST_MAX    = 64;
    localparam int MAX_PRINTS  = 100;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    sub_req_t pending[$];
    sub_req_t history[$];
    sub_rsp_t expected_rsp[$];

    logic [MSG_W-1:0]   tbl_msg   [NUM_LINKS][TABLE_DEPTH];
    logic [QUEUE_W-1:0] tbl_queue [NUM_LINKS][TABLE_DEPTH];
    int unsigned        tbl_fill  [NUM_LINKS];

    int unsigned send_idle_pct = 15;
    int unsigned recv_idle_pct = 73;
    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_errors   = 0;
    int unsigned cycles     = 0;

    per_link_subscription_table_insert_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        for (int l = 0; l < NUM_LINKS; l++) tbl_fill[l] = 0;
    end

    // table update for one subscribe item; returns the status and fill it yields
    function automatic sub_rsp_t subscribe_outcome(sub_req_t req);
        sub_rsp_t    rsp;
        int unsigned cnt;
        logic        hit;
        hit = 1'b0;
        if (req.link >= NUM_LINKS) begin
            rsp.status = ST_FULL;
            rsp.fill   = '0;
            return rsp;
        end
        cnt = tbl_fill[req.link];
        if (cnt >= TABLE_DEPTH) begin
            rsp.status = ST_FULL;
        end else begin
            for (int i = 0; i < cnt; i++)
                if (tbl_msg[req.link][i] == req.msg && tbl_queue[req.link][i] == req.queue)
                    hit = 1'b1;
            if (hit) begin
                rsp.status = ST_DUPLICATE;
            end else begin
                tbl_msg[req.link][cnt]   = req.msg;
                tbl_queue[req.link][cnt] = req.queue;
                cnt++;
                tbl_fill[req.link] = cnt;
                rsp.status = ST_ADDED;
            end
        end
        rsp.fill = FILL_OUT_W'(cnt);
        return rsp;
    endfunction

    task automatic report(string what);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("tb: mismatch at cycle %0d: %s", cycles, what);
    endtask

    task automatic push_item(logic [LINK_W-1:0] link, logic [MSG_W-1:0] msg,
                             logic [QUEUE_W-1:0] queue);
        sub_req_t req;
        req.link  = link;
        req.msg   = msg;
        req.queue = queue;
        pending.push_back(req);
        n_queued++;
    endtask

    // one subscribe request: a few messages for one queue on one link, with repeats of earlier items, or noise
    task automatic queue_request();
        sub_req_t          req;
        logic [LINK_W-1:0] link;
        logic [QUEUE_W-1:0] queue;
        logic [MSG_W-1:0]  msg;
        int unsigned       n;
        if ($urandom_range(99) < 10) begin
            push_item(LINK_W'($urandom_range(NUM_LINKS - 1)), MSG_W'($urandom),
                      QUEUE_W'($urandom));
        end else begin
            if ($urandom_range(99) < 60)
                link = LINK_W'($urandom_range(3));
            else
                link = LINK_W'($urandom_range(NUM_LINKS - 1));
            if ($urandom_range(99) < 30 && history.size() != 0)
                queue = history[$urandom_range(history.size() - 1)].queue;
            else
                queue = QUEUE_W'($urandom);
            n = $urandom_range(5);
            repeat (n) begin
                if ($urandom_range(99) < 25 && history.size() != 0) begin
                    req = history[$urandom_range(history.size() - 1)];
                    push_item(req.link, req.msg, req.queue);
                end else begin
                    if ($urandom_range(99) < 20)
                        msg = MSG_W'($urandom_range(7));
                    else
                        msg = MSG_W'($urandom);
                    push_item(link, msg, queue);
                    history.push_back(pending[$]);
                    if (history.size() > HIST_MAX) void'(history.pop_front());
                end
            end
        end
    endtask

    // driver: presents pending items, predicts on each accepted item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_rsp.push_back(subscribe_outcome(sub_req_t'(s_tdata[REQ_W-1:0])));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_DATA_W'(pending.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure, checks each result item
    always @(posedge aclk) begin
        sub_rsp_t got;
        sub_rsp_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                got = sub_rsp_t'(m_tdata[RSP_W-1:0]);
                if (expected_rsp.size() == 0) begin
                    report($sformatf("unexpected result %h", m_tdata));
                end else begin
                    want = expected_rsp.pop_front();
                    if (got.status !== want.status)
                        report($sformatf("status %0d, want %0d", got.status, want.status));
                    if (got.fill !== want.fill)
                        report($sformatf("fill_count %0d, want %0d", got.fill, want.fill));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int unsigned target;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        push_item(4'd0, 16'h0000, 16'h0000);
        push_item(4'd0, 16'h0000, 16'h0000);
        push_item(4'd0, 16'hffff, 16'hffff);
        push_item(4'd0, 16'h0000, 16'hffff);
        push_item(4'd0, 16'hffff, 16'h0000);
        push_item(4'd15, 16'haaaa, 16'h5555);
        push_item(4'd15, 16'h5555, 16'haaaa);
        push_item(4'd15, 16'haaaa, 16'h5555);
        // multi-message request, then part of it again
        push_item(4'd7, 16'h0001, 16'h1234);
        push_item(4'd7, 16'h0002, 16'h1234);
        push_item(4'd7, 16'h0003, 16'h1234);
        push_item(4'd7, 16'h0002, 16'h1234);
        // same pair on another link is a fresh entry
        push_item(4'd8, 16'hffff, 16'hffff);

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 73;
                recv_idle_pct = 15;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            target = n_queued + PHASE_ITEMS;
            while (n_queued < target) queue_request();
            while (n_accepted != n_queued || expected_rsp.size() != 0) @(posedge aclk);
        end

        repeat (40) @(posedge aclk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ per_link_subscription_table_insert_core.f @@
design/plsti_pkg.sv
design/plsti_ram.sv
design/per_link_subscription_table_insert_core.sv
verif/tb.sv
